@@ hw/rtl/tmrm_pkg.sv @@
// Shared types and constants for the tile map ray marcher.
package tmrm_pkg;

    // Map size defaults
    localparam int MAP_ROWS_DEF = 64;
    localparam int MAP_COLS_DEF = 64;

    // Input field widths
    localparam int ROW_W    = 6;
    localparam int COL_W    = 6;
    localparam int ORIGIN_W = 19;
    localparam int DIR_W    = 12;

    // Output field widths
    localparam int TEX_W  = 2;
    localparam int TOFF_W = 5;
    localparam int DIST_W = 40;

    // Stream payload widths (padded to bytes)
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 48;

    // Step limit register
    localparam int              STEPS_W       = 16;
    localparam logic [STEPS_W-1:0] MAX_STEPS_RST = 16'd8192;

    // Internal position: signed Q8 pixels wide enough for a 256-cell map plus one step
    localparam int POS_W      = 24;
    localparam int TILE_SHIFT = 13;
    localparam int CELL_W     = POS_W - 1 - TILE_SHIFT;
    localparam int MAG_W      = POS_W - 1;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int STEP_W     = 11;

    // x / 5 for x below 2^16: (x * 0xCCCD) >> 18
    localparam logic [15:0] RECIP5       = 16'hCCCD;
    localparam int          RECIP5_SHIFT = 18;

    // Texture codes
    localparam logic [TEX_W-1:0] TEX_VERT_NEG = 2'd0;
    localparam logic [TEX_W-1:0] TEX_VERT_POS = 2'd1;
    localparam logic [TEX_W-1:0] TEX_HORZ_NEG = 2'd2;
    localparam logic [TEX_W-1:0] TEX_HORZ_POS = 2'd3;

    // Result status codes
    localparam logic STAT_HIT  = 1'b0;
    localparam logic STAT_MISS = 1'b1;

    // Item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_CAST  = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic take;        // input channel ready
        logic clr_step;    // clear one map entry
        logic setup;       // derive steps, start at origin
        logic probe_back;  // probe address is the back cell
        logic rd_en;       // issue map read at probe address
        logic advance;     // move one step
        logic mark_side;   // record struck side
        logic side_vert;   // side value to record
        logic diff;        // absolute offsets from origin
        logic sq_x;        // square x offset
        logic sq_y;        // square y offset
        logic out_hit;     // load hit result
        logic out_miss;    // load no-hit result
    } tmrm_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;    // last entry of the clearing pass
        logic off_map;     // probe position outside the map
        logic wall;        // map read data
        logic step_limit;  // step count reached max_steps
        logic out_full;    // result register occupied
    } tmrm_stat_t;

endpackage

@@ hw/rtl/tile_map_ray_march.sv @@
// Top level of the tile map ray marcher.
// A cell write leaves the input ready again on the next cycle.
// A ray cast runs a setup step, then a march loop that reads the map and then evaluates each
// tested cell (one map read port), then a read of the back cell (skipped if off the map),
// the offsets, both squares and the result load; a no-hit result skips the distance steps.
// One item is in work at a time; a finished result waits in the output register.
// Reset (aresetn low, synchronous) starts a clearing pass over MAP_ROWS * 2^clog2(MAP_COLS)
// map entries (4096 by default) with s_tready low; configuration writes are taken throughout.
module tile_map_ray_march #(
    parameter int MAP_ROWS = tmrm_pkg::MAP_ROWS_DEF,
    parameter int MAP_COLS = tmrm_pkg::MAP_COLS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // config: max_steps
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tmrm_pkg::STEPS_W-1:0]   cfg_data,
    // input channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // cell_row[5:0] cell_col[11:6] cell_is_wall[12] origin_x[31:13]
    // origin_y[50:32] dir_x[62:51] dir_y[74:63], zero pad to 80
    input  logic [tmrm_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tuser,   // kind[0]
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // texture[1:0] tile_offset[6:2] distance_sq[46:7], zero pad to 48
    output logic [tmrm_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tuser    // status[0]
);

    tmrm_pkg::tmrm_cmd_t  cmd;
    tmrm_pkg::tmrm_stat_t stat;

    assign cfg_ready = 1'b1;
    assign s_tready  = cmd.take;

    tmrm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    tmrm_datapath #(
        .MAP_ROWS (MAP_ROWS),
        .MAP_COLS (MAP_COLS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

@@ hw/rtl/tmrm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tmrm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/tmrm_datapath.sv @@
// Datapath of the ray marcher: map store, march position, distance and result register.
module tmrm_datapath #(
    parameter int MAP_ROWS = tmrm_pkg::MAP_ROWS_DEF,
    parameter int MAP_COLS = tmrm_pkg::MAP_COLS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic [tmrm_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tuser,
    input  logic                           cfg_valid,
    input  logic [tmrm_pkg::STEPS_W-1:0]   cfg_data,
    input  tmrm_pkg::tmrm_cmd_t            cmd,
    output tmrm_pkg::tmrm_stat_t           stat,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic [tmrm_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tuser
);

    localparam int RW    = $clog2(MAP_ROWS);
    localparam int CW    = $clog2(MAP_COLS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = MAP_ROWS * (2 ** CW);
    localparam int IDX_W = 9;
    localparam int POS_W = tmrm_pkg::POS_W;
    localparam int MAG_W = tmrm_pkg::MAG_W;
    localparam int SQ_W  = tmrm_pkg::SQ_W;
    localparam int SUM_W = SQ_W + 1;
    localparam int TS    = tmrm_pkg::TILE_SHIFT;
    localparam int CELLW = tmrm_pkg::CELL_W;
    localparam int DIRW  = tmrm_pkg::DIR_W;
    localparam int OW    = tmrm_pkg::ORIGIN_W;
    localparam int SW    = tmrm_pkg::STEP_W;
    localparam int DW    = tmrm_pkg::DIST_W;

    localparam logic [AW-1:0]    CLR_LAST  = AW'(DEPTH - 1);
    localparam logic [IDX_W-1:0] ROW_LIM   = IDX_W'(MAP_ROWS);
    localparam logic [IDX_W-1:0] COL_LIM   = IDX_W'(MAP_COLS);
    localparam logic [CELLW-1:0] CROW_LIM  = CELLW'(MAP_ROWS);
    localparam logic [CELLW-1:0] CCOL_LIM  = CELLW'(MAP_COLS);

    // Input fields
    logic [tmrm_pkg::ROW_W-1:0] in_row;
    logic [tmrm_pkg::COL_W-1:0] in_col;
    logic                       in_wall;
    logic [OW-1:0]              in_ox, in_oy;
    logic [DIRW-1:0]            in_dx, in_dy;

    assign in_row  = s_tdata[5:0];
    assign in_col  = s_tdata[11:6];
    assign in_wall = s_tdata[12];
    assign in_ox   = s_tdata[31:13];
    assign in_oy   = s_tdata[50:32];
    assign in_dx   = s_tdata[62:51];
    assign in_dy   = s_tdata[74:63];

    logic accept;
    assign accept = s_tvalid && cmd.take;

    // Truncated (2 * d) / 5 through a reciprocal multiply on the magnitude
    function automatic logic signed [SW-1:0] step_of(input logic [DIRW-1:0] d);
        logic signed [DIRW+1:0] twice;
        logic        [DIRW:0]   mag;
        logic        [DIRW+16:0] prod;
        logic        [SW-1:0]   q;
        twice = {d[DIRW-1], d, 1'b0};
        mag   = twice[DIRW+1] ? (DIRW+1)'(-twice) : (DIRW+1)'(twice);
        prod  = (DIRW+17)'(mag) * (DIRW+17)'(tmrm_pkg::RECIP5);
        q     = prod[DIRW+16:tmrm_pkg::RECIP5_SHIFT];
        step_of = twice[DIRW+1] ? -$signed(q) : $signed(q);
    endfunction

    // Registers
    logic [AW-1:0]                clr_cnt_reg;
    logic [tmrm_pkg::STEPS_W-1:0] max_steps_reg;
    logic [tmrm_pkg::STEPS_W-1:0] steps_reg;
    logic [OW-1:0]                ox_reg, oy_reg;
    logic [DIRW-1:0]              dx_reg, dy_reg;
    logic signed [SW-1:0]         sx_reg, sy_reg;
    logic signed [POS_W-1:0]      px_reg, py_reg;
    logic                         vert_reg;
    logic [MAG_W-1:0]             ux_reg, uy_reg;
    logic [SQ_W-1:0]              sqx_reg, sqy_reg;
    logic                         m_tvalid_reg;
    logic [tmrm_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                         m_tuser_reg;

    // Probe position and its cell
    logic signed [POS_W-1:0] probe_y;
    logic [CELLW-1:0]        cx, cy;
    logic                    off_map;
    logic [AW-1:0]           raddr;

    assign probe_y = cmd.probe_back ? (py_reg - POS_W'($signed(dy_reg))) : py_reg;
    assign cx      = px_reg[POS_W-2:TS];
    assign cy      = probe_y[POS_W-2:TS];
    assign off_map = px_reg[POS_W-1] || probe_y[POS_W-1] || (cx >= CCOL_LIM) || (cy >= CROW_LIM);
    assign raddr   = {cy[RW-1:0], cx[CW-1:0]};

    // Map write port: clearing pass or cell write
    logic [IDX_W-1:0] row_x, col_x;
    logic             we;
    logic [AW-1:0]    waddr;
    logic             wdata;
    logic             rd_wall;

    assign row_x = IDX_W'(in_row);
    assign col_x = IDX_W'(in_col);

    always_comb begin
        if (cmd.clr_step) begin
            we    = 1'b1;
            waddr = clr_cnt_reg;
            wdata = 1'b0;
        end else begin
            we    = accept && (s_tuser == tmrm_pkg::KIND_WRITE) &&
                    (row_x < ROW_LIM) && (col_x < COL_LIM);
            waddr = {row_x[RW-1:0], col_x[CW-1:0]};
            wdata = in_wall;
        end
    end

    tmrm_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_map (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rd_wall)
    );

    // Offsets from origin
    logic signed [POS_W-1:0] ex, ey;
    assign ex = px_reg - POS_W'(ox_reg);
    assign ey = py_reg - POS_W'(oy_reg);

    // Result assembly
    logic [SUM_W-1:0]          dsum;
    logic [DW-1:0]             dsat;
    logic                      dx_pos, dy_pos;
    logic [tmrm_pkg::TEX_W-1:0]  tex;
    logic [tmrm_pkg::TOFF_W-1:0] toff;

    assign dsum   = SUM_W'(sqx_reg) + SUM_W'(sqy_reg);
    assign dsat   = (dsum[SUM_W-1:DW] != '0) ? '1 : dsum[DW-1:0];
    assign dx_pos = !dx_reg[DIRW-1] && (dx_reg != '0);
    assign dy_pos = !dy_reg[DIRW-1] && (dy_reg != '0);

    always_comb begin
        if (vert_reg) begin
            tex  = dx_pos ? tmrm_pkg::TEX_VERT_POS : tmrm_pkg::TEX_VERT_NEG;
            toff = py_reg[TS-1:8];
        end else begin
            tex  = dy_pos ? tmrm_pkg::TEX_HORZ_POS : tmrm_pkg::TEX_HORZ_NEG;
            toff = px_reg[TS-1:8];
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg   <= '0;
            max_steps_reg <= tmrm_pkg::MAX_STEPS_RST;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cmd.clr_step) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cfg_valid) begin
                max_steps_reg <= cfg_data;
            end
            if (cmd.out_hit || cmd.out_miss) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept && (s_tuser == tmrm_pkg::KIND_CAST)) begin
            ox_reg <= in_ox;
            oy_reg <= in_oy;
            dx_reg <= in_dx;
            dy_reg <= in_dy;
        end
        if (cmd.setup) begin
            sx_reg    <= step_of(dx_reg);
            sy_reg    <= step_of(dy_reg);
            px_reg    <= POS_W'(ox_reg);
            py_reg    <= POS_W'(oy_reg);
            steps_reg <= '0;
        end else if (cmd.advance) begin
            px_reg    <= px_reg + POS_W'(sx_reg);
            py_reg    <= py_reg + POS_W'(sy_reg);
            steps_reg <= steps_reg + tmrm_pkg::STEPS_W'(1);
        end
        if (cmd.mark_side) begin
            vert_reg <= cmd.side_vert;
        end
        if (cmd.diff) begin
            ux_reg <= ex[POS_W-1] ? MAG_W'(-ex) : MAG_W'(ex);
            uy_reg <= ey[POS_W-1] ? MAG_W'(-ey) : MAG_W'(ey);
        end
        if (cmd.sq_x) begin
            sqx_reg <= SQ_W'(ux_reg) * SQ_W'(ux_reg);
        end
        if (cmd.sq_y) begin
            sqy_reg <= SQ_W'(uy_reg) * SQ_W'(uy_reg);
        end
        if (cmd.out_hit) begin
            m_tdata_reg <= {1'b0, dsat, toff, tex};
            m_tuser_reg <= tmrm_pkg::STAT_HIT;
        end else if (cmd.out_miss) begin
            m_tdata_reg <= '0;
            m_tuser_reg <= tmrm_pkg::STAT_MISS;
        end
    end

    assign stat.clr_last   = (clr_cnt_reg == CLR_LAST);
    assign stat.off_map    = off_map;
    assign stat.wall       = rd_wall;
    assign stat.step_limit = (steps_reg >= max_steps_reg);
    assign stat.out_full   = m_tvalid_reg;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // A result is loaded only into an empty output register
    a_load_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_hit || cmd.out_miss) |-> !m_tvalid_reg)
        else $error("result loaded over a pending transaction");

    // Each advance bumps the step count by one
    a_step_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.advance && !cmd.setup) |=> (steps_reg == $past(steps_reg) + tmrm_pkg::STEPS_W'(1)))
        else $error("step count out of sequence");

    // The clearing pass owns the write port alone
    a_clear_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_step |-> (!cmd.take && !cmd.rd_en))
        else $error("map access during clearing pass");

endmodule

@@ hw/rtl/tmrm_ctrl.sv @@
// Controller state machine of the ray marcher.
module tmrm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tuser,
    input  tmrm_pkg::tmrm_stat_t  stat,
    output tmrm_pkg::tmrm_cmd_t   cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_PROBE,
        ST_CHECK,
        ST_BPROBE,
        ST_BCHECK,
        ST_DIFF,
        ST_SQX,
        ST_SQY,
        ST_HIT,
        ST_MISS
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                cmd.take = 1'b1;
                if (s_tvalid && (s_tuser == tmrm_pkg::KIND_CAST)) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = ST_PROBE;
            end
            ST_PROBE: begin
                if (stat.off_map) begin
                    state_next = ST_MISS;
                end else begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (stat.wall) begin
                    state_next = ST_BPROBE;
                end else if (stat.step_limit) begin
                    state_next = ST_MISS;
                end else begin
                    cmd.advance = 1'b1;
                    state_next  = ST_PROBE;
                end
            end
            ST_BPROBE: begin
                cmd.probe_back = 1'b1;
                if (stat.off_map) begin
                    // back cell off the map counts as open
                    cmd.mark_side = 1'b1;
                    cmd.side_vert = 1'b0;
                    state_next    = ST_DIFF;
                end else begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_BCHECK;
                end
            end
            ST_BCHECK: begin
                cmd.mark_side = 1'b1;
                cmd.side_vert = stat.wall;
                state_next    = ST_DIFF;
            end
            ST_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = ST_SQX;
            end
            ST_SQX: begin
                cmd.sq_x   = 1'b1;
                state_next = ST_SQY;
            end
            ST_SQY: begin
                cmd.sq_y   = 1'b1;
                state_next = ST_HIT;
            end
            ST_HIT: begin
                if (!stat.out_full) begin
                    cmd.out_hit = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_MISS: begin
                if (!stat.out_full) begin
                    cmd.out_miss = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Hit and no-hit results never load together
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.out_hit && cmd.out_miss))
        else $error("hit and no-hit loaded together");

    // A march step only follows a read that found an open cell
    a_adv_after_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.advance |-> ($past(cmd.rd_en) && !stat.wall))
        else $error("advance without a map read");

endmodule
